// File: hdl/assert_macros.svh
// Assertion macros shared by the enumerator RTL.
// No dependencies; define SYNTH to compile the checks away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Check sampled at the rising clock edge, masked while reset is low.
`define KSE_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);
// Check sampled at every rising clock edge, reset included.
`define KSE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define KSE_ASSERT(lbl, clk, rstn, prop, msg)
`define KSE_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// File: hdl/kse_pkg.sv
// Shared types and constants of the keyspace string enumerator.
// No dependencies; used by the interfaces, the cell row and the top level.
`default_nettype none
package kse_pkg;
	localparam int ADDR_W    = 64;
	localparam int CHAR_W    = 8;
	localparam int RADIX_W   = CHAR_W + 1;
	localparam int IL_W      = 5;
	localparam int CFG_IDX_W = 2;

	localparam logic [CHAR_W-1:0] RST_MIN_CHAR = 8'd33;
	localparam logic [CHAR_W-1:0] RST_MAX_CHAR = 8'd126;
	localparam logic [IL_W-1:0]   RST_INIT_LEN = 5'd1;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MIN_CHAR = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_CHAR = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INIT_LEN = 2'd2;

	// cell operations
	localparam logic [2:0] OP_HOLD    = 3'd0;
	localparam logic [2:0] OP_RESTART = 3'd1;
	localparam logic [2:0] OP_ADVANCE = 3'd2;
	localparam logic [2:0] OP_CLEAR   = 3'd3;
	localparam logic [2:0] OP_STEP    = 3'd4;
	localparam logic [2:0] OP_FINISH  = 3'd5;

	typedef struct packed {
		logic [2:0] op;
		logic       shift;
	} cell_cmd_t;

	typedef struct packed {
		logic [CHAR_W-1:0]  min_char;
		logic [CHAR_W-1:0]  max_char;
		logic [RADIX_W-1:0] radix;
	} cell_bcast_t;

	// data handed from one cell to the next higher one
	typedef struct packed {
		logic              adv_carry;
		logic              div_carry;
		logic              div_valid;
		logic [CHAR_W-1:0] sh;
	} cell_link_t;
endpackage
`default_nettype wire

// File: hdl/kse_in_if.sv
// Input channel: valid/ready handshake with action and address payload.
// Depends on kse_pkg.
`default_nettype none
interface kse_in_if;
	import kse_pkg::*;
	logic              valid;
	logic              ready;
	logic              action;
	logic [ADDR_W-1:0] address;
	modport source (output valid, action, address, input ready);
	modport sink (input valid, action, address, output ready);
endinterface
`default_nettype wire

// File: hdl/kse_out_if.sv
// Output channel: valid/ready handshake carrying one character per transaction.
// Depends on kse_pkg.
`default_nettype none
interface kse_out_if;
	import kse_pkg::*;
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] char_value;
	logic              is_last;
	logic              exhausted;
	modport source (output valid, char_value, is_last, exhausted, input ready);
	modport sink (input valid, char_value, is_last, exhausted, output ready);
endinterface
`default_nettype wire

// File: hdl/kse_cell.sv
// One character position of the enumerator: digit register, increment with
// carry, one radix doubling step of the address conversion, output shift stage.
// Depends on kse_pkg.
`default_nettype none
module kse_cell (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire kse_pkg::cell_cmd_t     cmd,
	input  wire kse_pkg::cell_bcast_t   bc,
	input  wire logic                   in_len,
	input  wire logic                   at_len,
	input  wire kse_pkg::cell_link_t    prev,
	output kse_pkg::cell_link_t         next,
	output logic                        nz
);
	import kse_pkg::*;

	logic [CHAR_W-1:0]  digit_q;
	logic [CHAR_W-1:0]  sh_q;
	logic               dcarry_q;
	logic               dvalid_q;
	logic               roll;
	logic               inc;
	logic [RADIX_W-1:0] dbl;
	logic               ge;
	logic [RADIX_W-1:0] rem;

	assign roll = (digit_q >= bc.max_char);
	assign inc  = prev.adv_carry & in_len;
	// doubling plus incoming bit, reduced once by the radix
	assign dbl  = {digit_q, prev.div_carry};
	assign ge   = (dbl >= bc.radix);
	assign rem  = ge ? (dbl - bc.radix) : dbl;

	assign next.adv_carry = in_len ? (prev.adv_carry & roll) : prev.adv_carry;
	assign next.div_carry = dcarry_q;
	assign next.div_valid = dvalid_q;
	assign next.sh        = sh_q;
	assign nz             = (digit_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_q  <= RST_MIN_CHAR;
			dcarry_q <= 1'b0;
			dvalid_q <= 1'b0;
		end else begin
			case (cmd.op)
				OP_RESTART: begin
					digit_q <= bc.min_char;
				end
				OP_ADVANCE: begin
					if (inc) begin
						digit_q <= roll ? bc.min_char : digit_q + 1'b1;
					end else if (at_len && prev.adv_carry) begin
						digit_q <= bc.min_char;
					end
				end
				OP_CLEAR: begin
					digit_q  <= '0;
					dcarry_q <= 1'b0;
					dvalid_q <= 1'b0;
				end
				OP_STEP: begin
					dvalid_q <= prev.div_valid;
					dcarry_q <= prev.div_valid & ge;
					if (prev.div_valid) begin
						digit_q <= rem[CHAR_W-1:0];
					end
				end
				OP_FINISH: begin
					digit_q  <= digit_q + bc.min_char;
					dcarry_q <= 1'b0;
					dvalid_q <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	// output shift stage, snapshot on advance
	always_ff @(posedge clk) begin
		if (cmd.op == OP_ADVANCE) begin
			sh_q <= digit_q;
		end else if (cmd.shift) begin
			sh_q <= prev.sh;
		end
	end
endmodule
`default_nettype wire

// File: hdl/kse_chain.sv
// Row of kse_cell instances, cell 0 holding the rightmost character.
// Depends on kse_pkg and kse_cell.
`default_nettype none
module kse_chain #(
	parameter int MAX_LEN = 16,
	parameter int LEN_W   = $clog2(MAX_LEN + 1),
	parameter int IDX_W   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire kse_pkg::cell_cmd_t        cmd,
	input  wire kse_pkg::cell_bcast_t      bc,
	input  wire logic [LEN_W-1:0]          len,
	input  wire logic [IDX_W-1:0]          tap_idx,
	input  wire logic                      head_bit,
	input  wire logic                      head_valid,
	output logic                           full_roll,
	output logic                           top_carry,
	output logic [kse_pkg::CHAR_W-1:0]     tap_char,
	output logic [LEN_W-1:0]               needed
);
	import kse_pkg::*;

	cell_link_t        lk     [MAX_LEN+1];
	logic [CHAR_W-1:0] sh_vec [MAX_LEN];
	logic [MAX_LEN-1:0] nz;

	assign lk[0] = '{adv_carry: 1'b1, div_carry: head_bit, div_valid: head_valid, sh: '0};

	for (genvar i = 0; i < MAX_LEN; i++) begin : g_cell
		localparam logic [LEN_W-1:0] IDX = LEN_W'(i);
		kse_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.cmd    (cmd),
			.bc     (bc),
			.in_len (IDX < len),
			.at_len (IDX == len),
			.prev   (lk[i]),
			.next   (lk[i+1]),
			.nz     (nz[i])
		);
		assign sh_vec[i] = lk[i+1].sh;
	end

	assign full_roll = lk[MAX_LEN].adv_carry;
	assign top_carry = lk[MAX_LEN].div_valid & lk[MAX_LEN].div_carry;
	assign tap_char  = sh_vec[tap_idx];

	// highest nonzero digit, as a length
	always_comb begin
		needed = '0;
		for (int i = 0; i < MAX_LEN; i++) begin
			if (nz[i]) begin
				needed = LEN_W'(i + 1);
			end
		end
	end
endmodule
`default_nettype wire

// File: hdl/keyspace_string_enumerator_top.sv
// Keyspace string enumerator: odometer over a character range, with a row
// of per-character cells. Depends on kse_pkg, kse_in_if, kse_out_if, kse_chain.
//
// Usage:
//  - in_ch carries one transaction per command. action 0 (next) emits the
//    current string on out_ch, leftmost character first, is_last on the
//    rightmost, then counts the string up by one in radix max-min+1.
//    action 1 (assign) loads the radix digits of address; it emits nothing.
//  - A next of an n-character string shows its first character in the cycle
//    after acceptance and one character per cycle while out_ch.ready is high;
//    in_ch is ready again the cycle after the last character is taken. A
//    stall on out_ch simply holds the current character; the string shifts
//    only on a completed output transaction.
//  - During an assign the address bits enter cell 0 MSB first and ripple up
//    the cell row as a skewed doubling-with-carry, one bit per cell per cycle.
//  - exhausted is sticky: set when the string wraps at MAX_LEN characters or
//    an assigned address needs more than MAX_LEN digits.
//  - Reset: min_char 33, max_char 126, initial_length 1, one character of
//    min_char. Writing initial_length restarts the string and clears exhausted;
//    the user writes configuration only while idle; the block does not check.
`default_nettype none
`include "assert_macros.svh"
module keyspace_string_enumerator_top #(
	parameter int MAX_LEN = 16
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_write,
	input  wire logic [kse_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [kse_pkg::CHAR_W-1:0]   cfg_data,
	kse_in_if.sink                            in_ch,
	kse_out_if.source                         out_ch
);
	import kse_pkg::*;

	localparam int LEN_W     = $clog2(MAX_LEN + 1);
	localparam int IDX_W     = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int STEP_LAST = ADDR_W + MAX_LEN - 1;
	localparam int CNT_W     = $clog2(STEP_LAST + 1);
	localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_LEN);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_ASG  = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;
	localparam logic [1:0] ST_OUT  = 2'd3;

	function automatic logic [LEN_W-1:0] clamp_len(input logic [IL_W-1:0] il);
		logic [LEN_W-1:0] r;
		if (il == '0) begin
			r = LEN_W'(1);
		end else if (int'(il) > MAX_LEN) begin
			r = LEN_MAX;
		end else begin
			r = LEN_W'(il);
		end
		return r;
	endfunction

	logic [1:0]        state_q;
	logic [CHAR_W-1:0] min_q;
	logic [CHAR_W-1:0] max_q;
	logic [LEN_W-1:0]  len_q;
	logic              exh_q;
	logic [ADDR_W-1:0] addr_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              ovf_q;
	logic [LEN_W-1:0]  olen_q;
	logic [LEN_W-1:0]  rem_q;
	logic              oexh_q;

	logic              in_acc;
	logic              out_acc;
	logic              restart;
	logic              ovf_now;
	logic              full_roll;
	logic              top_carry;
	logic [CHAR_W-1:0] tap_char;
	logic [LEN_W-1:0]  needed;
	logic [IDX_W-1:0]  tap_idx;
	cell_cmd_t         cmd;
	cell_bcast_t       bc;

	assign in_ch.ready  = (state_q == ST_IDLE);
	assign out_ch.valid = (state_q == ST_OUT);
	assign in_acc       = in_ch.valid & in_ch.ready;
	assign out_acc      = out_ch.valid & out_ch.ready;
	assign restart      = cfg_write && (cfg_index == REG_INIT_LEN);
	assign ovf_now      = ovf_q | top_carry;

	// degenerate range counts as radix one
	assign bc.min_char = min_q;
	assign bc.max_char = max_q;
	assign bc.radix    = (max_q > min_q) ?
		({1'b0, max_q} - {1'b0, min_q} + RADIX_W'(1)) : RADIX_W'(1);

	always_comb begin
		cmd.shift = out_acc;
		if (restart) begin
			cmd.op = OP_RESTART;
		end else if (in_acc) begin
			cmd.op = in_ch.action ? OP_CLEAR : OP_ADVANCE;
		end else begin
			case (state_q)
				ST_ASG:  cmd.op = OP_STEP;
				ST_FIN:  cmd.op = OP_FINISH;
				default: cmd.op = OP_HOLD;
			endcase
		end
	end

	assign tap_idx = IDX_W'(olen_q - 1'b1);

	kse_chain #(
		.MAX_LEN (MAX_LEN),
		.LEN_W   (LEN_W),
		.IDX_W   (IDX_W)
	) u_chain (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.bc         (bc),
		.len        (len_q),
		.tap_idx    (tap_idx),
		.head_bit   (addr_q[ADDR_W-1]),
		.head_valid ((state_q == ST_ASG) && (int'(cnt_q) < ADDR_W)),
		.full_roll  (full_roll),
		.top_carry  (top_carry),
		.tap_char   (tap_char),
		.needed     (needed)
	);

	assign out_ch.char_value = tap_char;
	assign out_ch.is_last    = (rem_q == LEN_W'(1));
	assign out_ch.exhausted  = oexh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			min_q   <= RST_MIN_CHAR;
			max_q   <= RST_MAX_CHAR;
			len_q   <= clamp_len(RST_INIT_LEN);
			exh_q   <= 1'b0;
			cnt_q   <= '0;
			ovf_q   <= 1'b0;
			olen_q  <= LEN_W'(1);
			rem_q   <= '0;
			oexh_q  <= 1'b0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					REG_MIN_CHAR: min_q <= cfg_data;
					REG_MAX_CHAR: max_q <= cfg_data;
					REG_INIT_LEN: begin
						len_q  <= clamp_len(cfg_data[IL_W-1:0]);
						exh_q  <= 1'b0;
					end
					default: begin
					end
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (in_ch.action) begin
							cnt_q   <= '0;
							ovf_q   <= 1'b0;
							state_q <= ST_ASG;
						end else begin
							olen_q  <= len_q;
							rem_q   <= len_q;
							oexh_q  <= exh_q | (full_roll && (len_q == LEN_MAX));
							// carry out of every position: grow or wrap
							if (full_roll) begin
								if (len_q < LEN_MAX) begin
									len_q <= len_q + 1'b1;
								end else begin
									exh_q <= 1'b1;
								end
							end
							state_q <= ST_OUT;
						end
					end
				end
				ST_ASG: begin
					cnt_q <= cnt_q + 1'b1;
					ovf_q <= ovf_now;
					if (cnt_q == CNT_W'(STEP_LAST)) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (ovf_now) begin
						len_q <= LEN_MAX;
						exh_q <= 1'b1;
					end else if (needed > len_q) begin
						len_q <= needed;
					end
					state_q <= ST_IDLE;
				end
				ST_OUT: begin
					if (out_acc) begin
						rem_q <= rem_q - 1'b1;
						if (rem_q == LEN_W'(1)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// address shift register, MSB feeds cell 0
	always_ff @(posedge clk) begin
		if (in_acc && in_ch.action) begin
			addr_q <= in_ch.address;
		end else if (state_q == ST_ASG) begin
			addr_q <= {addr_q[ADDR_W-2:0], 1'b0};
		end
	end

	`KSE_ASSERT(a_no_overlap, clk, arst_n, out_ch.valid |-> !in_ch.ready, "input taken while emitting")
	`KSE_ASSERT(a_last_ends, clk, arst_n, (out_acc && out_ch.is_last) |=> !out_ch.valid, "output ran past last character")
	`KSE_ASSERT(a_assign_quiet, clk, arst_n, (in_acc && in_ch.action) |=> (state_q == ST_ASG) && !out_ch.valid, "assign produced output")
	`KSE_ASSERT(a_len_range, clk, arst_n, (len_q != '0) && (int'(len_q) <= MAX_LEN), "string length out of range")
endmodule
`default_nettype wire
